// ----- rtl/cpva_pkg.sv -----
package cpva_pkg;

  localparam int SLOT_BITS = 32;
  localparam int NV        = 14;
  localparam int IN_BITS   = NV * SLOT_BITS;
  localparam int OUT_BITS  = 4 * SLOT_BITS;
  localparam int USER_BITS = 2;

  // value slots of the input item, lowest first
  localparam int V_A   = 0;
  localparam int V_B   = 1;
  localparam int V_C   = 2;
  localparam int V_GX  = 3;
  localparam int V_GY  = 4;
  localparam int V_XXX = 5;
  localparam int V_XXY = 6;
  localparam int V_XYY = 7;
  localparam int V_YYY = 8;
  localparam int V_XXT = 9;
  localparam int V_XYT = 10;
  localparam int V_YYT = 11;
  localparam int V_XTT = 12;
  localparam int V_YTT = 13;

  // result lanes and user bits
  localparam int O_VX = 0;
  localparam int O_VY = 1;
  localparam int O_AX = 2;
  localparam int O_AY = 3;
  localparam int USR_VALID = 0;
  localparam int USR_SAT   = 1;

  localparam int TOL_BITS = 16;
  localparam logic [TOL_BITS-1:0] TOL_RESET = 16'd66;
  localparam logic [TOL_BITS:0]   TOL_ONE   = 17'h10000;

endpackage

// ----- rtl/cpva_div.sv -----
module cpva_div #(
  parameter int DW = 32,
  parameter int FB = 16,
  parameter int PW = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic [1:0][2*DW-1:0] nm,
  input  logic [1:0]           nneg,
  input  logic [2*DW-1:0]      dm,
  input  logic                 dneg,
  input  logic [PW-1:0]        pay_in,
  output logic                 out_vld,
  output logic [1:0][DW-1:0]   q,
  output logic                 sat,
  output logic [PW-1:0]        pay_out
);

  localparam int NW = 2 * DW;
  localparam int SH = DW - FB;
  localparam int CW = NW + SH;
  localparam logic [DW-1:0] HALF = DW'(1) << (DW - 1);

  logic [DW:0]             vld;
  logic [1:0][NW-1:0]      rem [DW+1];
  logic [1:0][DW-1:0]      quo [DW+1];
  logic [1:0][DW-1:0]      low [DW+1];
  logic [1:0]              ovf [DW+1];
  logic [1:0]              ng  [DW+1];
  logic [NW-1:0]           dv  [DW+1];
  logic                    dn  [DW+1];
  logic [PW-1:0]           pay [DW+1];

  logic [1:0]              ovf0;
  logic [1:0][NW-1:0]      rem0;
  logic [1:0][DW-1:0]      low0;
  logic [1:0][DW-1:0]      res;
  logic                    sat_c;

  // quotient beyond the lane width, and the starting remainder
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      ovf0[l] = CW'(nm[l]) >= (CW'(dm) << SH);
      rem0[l] = nm[l] >> SH;
      low0[l] = nm[l][DW-1:0] << FB;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DW-1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= rem0;
      quo[0] <= '0;
      low[0] <= low0;
      ovf[0] <= ovf0;
      ng[0]  <= nneg;
      dv[0]  <= dm;
      dn[0]  <= dneg;
      pay[0] <= pay_in;
    end
  end

  for (genvar k = 1; k <= DW; k++) begin : g_step
    logic [1:0][NW-1:0] rn;
    logic [1:0]         qb;

    always_comb begin
      logic [NW:0] trial;
      for (int l = 0; l < 2; l++) begin
        trial = {rem[k-1][l], low[k-1][l][DW-1]};
        qb[l] = trial >= {1'b0, dv[k-1]};
        rn[l] = qb[l] ? NW'(trial - {1'b0, dv[k-1]}) : trial[NW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= rn;
        for (int l = 0; l < 2; l++) begin
          quo[k][l] <= {quo[k-1][l][DW-2:0], qb[l]};
          low[k][l] <= low[k-1][l] << 1;
        end
        ovf[k] <= ovf[k-1];
        ng[k]  <= ng[k-1];
        dv[k]  <= dv[k-1];
        dn[k]  <= dn[k-1];
        pay[k] <= pay[k-1];
      end
    end
  end

  // negate, clip to the signed lane range
  always_comb begin
    logic          rneg;
    logic [DW-1:0] cap;
    logic          over;
    logic [DW-1:0] mag;
    sat_c = 1'b0;
    for (int l = 0; l < 2; l++) begin
      rneg   = ~(ng[DW][l] ^ dn[DW]);
      cap    = rneg ? HALF : HALF - DW'(1);
      over   = ovf[DW][l] || (quo[DW][l] > cap);
      mag    = over ? cap : quo[DW][l];
      res[l] = rneg ? -mag : mag;
      sat_c  = sat_c | over;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= vld[DW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q       <= res;
      sat     <= sat_c;
      pay_out <= pay[DW];
    end
  end

endmodule

// ----- rtl/critical_point_velocity_acceleration_top.sv -----
// Critical point velocity and acceleration. Each item carries the Hessian, the time
// derivative of the gradient and the third derivatives at one point, all signed
// fixed point with FRAC_BITS fraction bits in the low DATA_WIDTH bits of 32-bit
// slots. The result gives point_valid, the velocity -inv(H) gt and the acceleration
// -inv(H) R with saturation; a point whose reciprocal condition number is at or
// below cond_tolerance (unsigned Q0.16, reset 66) comes out as all zeros. One item
// is taken every clock unless the output stalls, and results leave in input order; most of the
// pipeline depth is in the two bit-per-stage dividers, DATA_WIDTH+2 stages each. A full output
// stage that is not taken stalls the whole pipeline, no item is lost. The user must write
// cond_tolerance only while the pipeline is empty; the block itself does not enforce this.
module critical_point_velocity_acceleration_top
  import cpva_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wen,
  input  logic [TOL_BITS-1:0]  cfg_wdata,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // hess_xx, hess_xy, hess_yy, grad_t_pair, third_xxx, third_xxy, third_xyy,
  // third_yyy, third_xxt, third_xyt, third_yyt, third_tt_pair
  input  logic [IN_BITS-1:0]   s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // vel_x, vel_y, acc_x, acc_y
  output logic [OUT_BITS-1:0]  m_axis_tdata,
  // point_valid, saturated
  output logic [USER_BITS-1:0] m_axis_tuser
);

  localparam int DW  = DATA_WIDTH;
  localparam int FB  = FRAC_BITS;
  localparam int NW  = 2 * DW;
  localparam int RW  = NW + 1 - FB;
  localparam int SW  = RW + 4;
  localparam int KW  = TOL_BITS + 1;
  localparam int LW  = NW + 2 + TOL_BITS;
  localparam int CW  = NW + 2 * KW;
  localparam int PW1 = NW + 2 + NV * DW;
  localparam int PW2 = 2 * DW + 2;
  localparam int MW  = 2 * KW + DW;
  localparam logic [NW:0] RHALF = (NW + 1)'(1) << (FB - 1);
  localparam logic signed [SW-1:0] CMAX = {{(SW - DW + 1){1'b0}}, {(DW - 1){1'b1}}};
  localparam logic signed [SW-1:0] CMIN = ~CMAX;

  typedef logic [NV-1:0][DW-1:0] vec_t;

  // round half up to FB fraction bits
  function automatic logic signed [RW-1:0] rnd(input logic signed [NW-1:0] p);
    logic signed [NW:0] t;
    t = $signed({p[NW-1], p}) + $signed(RHALF);
    return RW'(t >>> FB);
  endfunction

  // {clipped flag, value}
  function automatic logic [DW:0] clip(input logic signed [SW-1:0] v);
    if (v > CMAX) begin
      return {1'b1, CMAX[DW-1:0]};
    end else if (v < CMIN) begin
      return {1'b1, CMIN[DW-1:0]};
    end
    return {1'b0, v[DW-1:0]};
  endfunction

  logic en;
  logic o_vld;
  logic [TOL_BITS-1:0] cond_tol;

  assign en            = !o_vld || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = o_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      cond_tol <= TOL_RESET;
    end else if (cfg_wen) begin
      cond_tol <= cfg_wdata;
    end
  end

  // conditioning and velocity numerators
  logic [7:1] pvld;
  vec_t p1_v, p2_v, p3_v, p4_v, p5_v, p6_v, p7_v;
  logic signed [NW-1:0] p2_ac, p2_bb, p2_cgx, p2_bgy, p2_agy, p2_bgx;
  logic signed [DW:0]   p2_tr;
  logic signed [NW:0]   p3_det, p3_dfx, p3_dfy;
  logic [DW:0]          p3_trm;
  logic [NW-1:0]        p4_detm, p4_nmx, p4_nmy;
  logic                 p4_dneg, p4_dzero, p4_negx, p4_negy;
  logic [NW+1:0]        p4_trm2;
  logic [KW-1:0]        p4_kp;
  logic [NW-1:0]        p5_detm, p5_nmx, p5_nmy;
  logic                 p5_dneg, p5_dzero, p5_negx, p5_negy;
  logic [LW-1:0]        p5_lhs;
  logic [2*KW-1:0]      p5_kk;
  logic [NW-1:0]        p6_detm, p6_nmx, p6_nmy;
  logic                 p6_dneg, p6_dzero, p6_negx, p6_negy;
  logic [LW-1:0]        p6_lhs;
  logic [2*KW+DW-1:0]   p6_rlo, p6_rhi;
  logic [NW-1:0]        p7_detm, p7_nmx, p7_nmy;
  logic                 p7_dneg, p7_degen, p7_negx, p7_negy;

  always_ff @(posedge clk) begin
    if (rst) begin
      pvld <= '0;
    end else if (en) begin
      pvld <= {pvld[6:1], s_axis_tvalid && s_axis_tready};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NV; i++) begin
        p1_v[i] <= s_axis_tdata[i*SLOT_BITS +: DW];
      end

      p2_v   <= p1_v;
      p2_ac  <= NW'($signed(p1_v[V_A])) * NW'($signed(p1_v[V_C]));
      p2_bb  <= NW'($signed(p1_v[V_B])) * NW'($signed(p1_v[V_B]));
      p2_cgx <= NW'($signed(p1_v[V_C])) * NW'($signed(p1_v[V_GX]));
      p2_bgy <= NW'($signed(p1_v[V_B])) * NW'($signed(p1_v[V_GY]));
      p2_agy <= NW'($signed(p1_v[V_A])) * NW'($signed(p1_v[V_GY]));
      p2_bgx <= NW'($signed(p1_v[V_B])) * NW'($signed(p1_v[V_GX]));
      p2_tr  <= (DW + 1)'($signed(p1_v[V_A])) + (DW + 1)'($signed(p1_v[V_C]));

      p3_v   <= p2_v;
      p3_det <= (NW + 1)'(p2_ac) - (NW + 1)'(p2_bb);
      p3_dfx <= (NW + 1)'(p2_cgx) - (NW + 1)'(p2_bgy);
      p3_dfy <= (NW + 1)'(p2_agy) - (NW + 1)'(p2_bgx);
      p3_trm <= p2_tr[DW] ? -p2_tr : p2_tr;

      p4_v     <= p3_v;
      p4_detm  <= NW'(p3_det[NW] ? -p3_det : p3_det);
      p4_dneg  <= p3_det[NW];
      p4_dzero <= p3_det == '0;
      p4_nmx   <= NW'(p3_dfx[NW] ? -p3_dfx : p3_dfx);
      p4_negx  <= p3_dfx[NW];
      p4_nmy   <= NW'(p3_dfy[NW] ? -p3_dfy : p3_dfy);
      p4_negy  <= p3_dfy[NW];
      p4_trm2  <= (NW + 2)'(p3_trm) * (NW + 2)'(p3_trm);
      p4_kp    <= p3_det[NW] ? TOL_ONE - KW'(cond_tol) : TOL_ONE + KW'(cond_tol);

      p5_v     <= p4_v;
      p5_detm  <= p4_detm;
      p5_dneg  <= p4_dneg;
      p5_dzero <= p4_dzero;
      p5_nmx   <= p4_nmx;
      p5_negx  <= p4_negx;
      p5_nmy   <= p4_nmy;
      p5_negy  <= p4_negy;
      p5_lhs   <= LW'(p4_trm2) * LW'(cond_tol);
      p5_kk    <= (2 * KW)'(p4_kp) * (2 * KW)'(p4_kp);

      p6_v     <= p5_v;
      p6_detm  <= p5_detm;
      p6_dneg  <= p5_dneg;
      p6_dzero <= p5_dzero;
      p6_nmx   <= p5_nmx;
      p6_negx  <= p5_negx;
      p6_nmy   <= p5_nmy;
      p6_negy  <= p5_negy;
      p6_lhs   <= p5_lhs;
      p6_rlo   <= MW'(p5_kk) * MW'(p5_detm[DW-1:0]);
      p6_rhi   <= MW'(p5_kk) * MW'(p5_detm[NW-1:DW]);

      p7_v     <= p6_v;
      p7_detm  <= p6_detm;
      p7_dneg  <= p6_dneg;
      p7_nmx   <= p6_nmx;
      p7_negx  <= p6_negx;
      p7_nmy   <= p6_nmy;
      p7_negy  <= p6_negy;
      p7_degen <= p6_dzero ||
                  ({p6_lhs, {TOL_BITS{1'b0}}} >= (CW'(p6_rlo) + (CW'(p6_rhi) << DW)));
    end
  end

  // velocity division
  logic                 d1_vld, d1_sat;
  logic [1:0][DW-1:0]   d1_q;
  logic [PW1-1:0]       d1_pay;
  logic                 d1_degen, d1_dneg;
  logic [NW-1:0]        d1_detm;
  vec_t                 d1_v;

  cpva_div #(.DW(DW), .FB(FB), .PW(PW1)) u_div_vel (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (pvld[7]),
    .nm      ({p7_nmy, p7_nmx}),
    .nneg    ({p7_negy, p7_negx}),
    .dm      (p7_detm),
    .dneg    (p7_dneg),
    .pay_in  ({p7_degen, p7_dneg, p7_detm, p7_v}),
    .out_vld (d1_vld),
    .q       (d1_q),
    .sat     (d1_sat),
    .pay_out (d1_pay)
  );

  assign d1_degen = d1_pay[PW1-1];
  assign d1_dneg  = d1_pay[PW1-2];
  assign d1_detm  = d1_pay[NV*DW +: NW];
  assign d1_v     = d1_pay[NV*DW-1:0];

  // second order terms and acceleration numerators
  logic [7:1] qvld;
  vec_t q1_v, q2_v, q3_v, q4_v;
  logic [7:1] q_degen, q_dneg, q_sat;
  logic [NW-1:0] q_detm [7:1];
  logic signed [DW-1:0] q_ux [7:1];
  logic signed [DW-1:0] q_uy [7:1];
  logic signed [NW-1:0] q1_pxx, q1_pxy, q1_pyy, q1_t0a, q1_t0b, q1_t1a, q1_t1b;
  logic signed [DW-1:0] q2_sxx, q2_sxy, q2_syy;
  logic signed [RW:0]   q2_lin0, q2_lin1, q3_lin0, q3_lin1;
  logic signed [NW-1:0] q3_m0, q3_m1, q3_m2, q3_n0, q3_n1, q3_n2;
  logic signed [DW-1:0] q4_r0, q4_r1;
  logic signed [NW-1:0] q5_cr0, q5_br1, q5_ar1, q5_br0;
  logic signed [NW:0]   q6_dax, q6_day;
  logic [NW-1:0]        q7_nmx, q7_nmy;
  logic                 q7_negx, q7_negy;
  logic [DW:0]          cl_xx, cl_xy, cl_yy, cl_r0, cl_r1;
  logic signed [SW-1:0] s_r0, s_r1;

  always_comb begin
    cl_xx = clip(SW'(rnd(q1_pxx)));
    cl_xy = clip(SW'(rnd(q1_pxy)));
    cl_yy = clip(SW'(rnd(q1_pyy)));
    s_r0  = SW'($signed(q3_v[V_XTT])) + (SW'(q3_lin0) <<< 1) + SW'(rnd(q3_m0))
          + (SW'(rnd(q3_m1)) <<< 1) + SW'(rnd(q3_m2));
    s_r1  = SW'($signed(q3_v[V_YTT])) + (SW'(q3_lin1) <<< 1) + SW'(rnd(q3_n0))
          + (SW'(rnd(q3_n1)) <<< 1) + SW'(rnd(q3_n2));
    cl_r0 = clip(s_r0);
    cl_r1 = clip(s_r1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qvld <= '0;
    end else if (en) begin
      qvld <= {qvld[6:1], d1_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q1_v       <= d1_v;
      q_degen[1] <= d1_degen;
      q_dneg[1]  <= d1_dneg;
      q_sat[1]   <= d1_sat;
      q_detm[1]  <= d1_detm;
      q_ux[1]    <= $signed(d1_q[0]);
      q_uy[1]    <= $signed(d1_q[1]);
      for (int s = 2; s <= 7; s++) begin
        q_degen[s] <= q_degen[s-1];
        q_dneg[s]  <= q_dneg[s-1];
        q_detm[s]  <= q_detm[s-1];
        q_ux[s]    <= q_ux[s-1];
        q_uy[s]    <= q_uy[s-1];
      end
      q_sat[2] <= q_sat[1] | cl_xx[DW] | cl_xy[DW] | cl_yy[DW];
      q_sat[3] <= q_sat[2];
      q_sat[4] <= q_sat[3] | cl_r0[DW] | cl_r1[DW];
      q_sat[5] <= q_sat[4];
      q_sat[6] <= q_sat[5];
      q_sat[7] <= q_sat[6];

      q1_pxx <= NW'($signed(d1_q[0])) * NW'($signed(d1_q[0]));
      q1_pxy <= NW'($signed(d1_q[0])) * NW'($signed(d1_q[1]));
      q1_pyy <= NW'($signed(d1_q[1])) * NW'($signed(d1_q[1]));
      q1_t0a <= NW'($signed(d1_v[V_XXT])) * NW'($signed(d1_q[0]));
      q1_t0b <= NW'($signed(d1_v[V_XYT])) * NW'($signed(d1_q[1]));
      q1_t1a <= NW'($signed(d1_v[V_XYT])) * NW'($signed(d1_q[0]));
      q1_t1b <= NW'($signed(d1_v[V_YYT])) * NW'($signed(d1_q[1]));

      q2_v    <= q1_v;
      q2_sxx  <= $signed(cl_xx[DW-1:0]);
      q2_sxy  <= $signed(cl_xy[DW-1:0]);
      q2_syy  <= $signed(cl_yy[DW-1:0]);
      q2_lin0 <= (RW + 1)'(rnd(q1_t0a)) + (RW + 1)'(rnd(q1_t0b));
      q2_lin1 <= (RW + 1)'(rnd(q1_t1a)) + (RW + 1)'(rnd(q1_t1b));

      q3_v    <= q2_v;
      q3_lin0 <= q2_lin0;
      q3_lin1 <= q2_lin1;
      q3_m0   <= NW'($signed(q2_v[V_XXX])) * NW'(q2_sxx);
      q3_m1   <= NW'($signed(q2_v[V_XXY])) * NW'(q2_sxy);
      q3_m2   <= NW'($signed(q2_v[V_XYY])) * NW'(q2_syy);
      q3_n0   <= NW'($signed(q2_v[V_XXY])) * NW'(q2_sxx);
      q3_n1   <= NW'($signed(q2_v[V_XYY])) * NW'(q2_sxy);
      q3_n2   <= NW'($signed(q2_v[V_YYY])) * NW'(q2_syy);

      q4_v  <= q3_v;
      q4_r0 <= $signed(cl_r0[DW-1:0]);
      q4_r1 <= $signed(cl_r1[DW-1:0]);

      q5_cr0 <= NW'($signed(q4_v[V_C])) * NW'(q4_r0);
      q5_br1 <= NW'($signed(q4_v[V_B])) * NW'(q4_r1);
      q5_ar1 <= NW'($signed(q4_v[V_A])) * NW'(q4_r1);
      q5_br0 <= NW'($signed(q4_v[V_B])) * NW'(q4_r0);

      q6_dax <= (NW + 1)'(q5_cr0) - (NW + 1)'(q5_br1);
      q6_day <= (NW + 1)'(q5_ar1) - (NW + 1)'(q5_br0);

      q7_nmx  <= NW'(q6_dax[NW] ? -q6_dax : q6_dax);
      q7_negx <= q6_dax[NW];
      q7_nmy  <= NW'(q6_day[NW] ? -q6_day : q6_day);
      q7_negy <= q6_day[NW];
    end
  end

  // acceleration division
  logic               d2_vld, d2_sat;
  logic [1:0][DW-1:0] d2_q;
  logic [PW2-1:0]     d2_pay;
  logic               d2_degen, d2_sat_in;
  logic [DW-1:0]      d2_ux, d2_uy;

  cpva_div #(.DW(DW), .FB(FB), .PW(PW2)) u_div_acc (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (qvld[7]),
    .nm      ({q7_nmy, q7_nmx}),
    .nneg    ({q7_negy, q7_negx}),
    .dm      (q_detm[7]),
    .dneg    (q_dneg[7]),
    .pay_in  ({q_degen[7], q_sat[7], q_uy[7], q_ux[7]}),
    .out_vld (d2_vld),
    .q       (d2_q),
    .sat     (d2_sat),
    .pay_out (d2_pay)
  );

  assign d2_degen  = d2_pay[PW2-1];
  assign d2_sat_in = d2_pay[PW2-2];
  assign d2_uy     = d2_pay[DW +: DW];
  assign d2_ux     = d2_pay[DW-1:0];

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else if (en) begin
      o_vld <= d2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (d2_degen) begin
        m_axis_tdata <= '0;
        m_axis_tuser <= '0;
      end else begin
        m_axis_tdata[O_VX*SLOT_BITS +: SLOT_BITS] <= SLOT_BITS'($signed(d2_ux));
        m_axis_tdata[O_VY*SLOT_BITS +: SLOT_BITS] <= SLOT_BITS'($signed(d2_uy));
        m_axis_tdata[O_AX*SLOT_BITS +: SLOT_BITS] <= SLOT_BITS'($signed(d2_q[0]));
        m_axis_tdata[O_AY*SLOT_BITS +: SLOT_BITS] <= SLOT_BITS'($signed(d2_q[1]));
        m_axis_tuser[USR_VALID] <= 1'b1;
        m_axis_tuser[USR_SAT]   <= d2_sat_in | d2_sat;
      end
    end
  end

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[USR_VALID] |->
      m_axis_tdata == '0 && !m_axis_tuser[USR_SAT])
    else $error("degenerate item with nonzero result");

  a_det_nonzero: assert property (@(posedge clk) disable iff (rst)
    d1_vld && !d1_degen |-> d1_detm != '0)
    else $error("well conditioned item with zero determinant");

  a_tol_reset: assert property (@(posedge clk)
    $past(rst) |-> cond_tol == TOL_RESET)
    else $error("tolerance not at reset value");

endmodule

// ----- tb/sv/critical_point_velocity_acceleration_top_test.sv -----
`timescale 1ns / 100ps

module critical_point_velocity_acceleration_top_test;
  import cpva_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 120;

  typedef struct packed {
    logic        point_valid;
    logic        saturated;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [31:0] acc_x;
    logic [31:0] acc_y;
  } point_motion_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wen = 1'b0;
  logic [TOL_BITS-1:0]  cfg_wdata = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_BITS-1:0]   s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_BITS-1:0]  m_axis_tdata;
  logic [USER_BITS-1:0] m_axis_tuser;

  logic [IN_BITS-1:0] pending_points[$];
  point_motion_t      expected_motion[$];
  logic [TOL_BITS-1:0] tolerance = TOL_RESET;
  int  errors = 0;
  int  cycles = 0;

  critical_point_velocity_acceleration_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_wdata    (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #10 clk = ~clk;

  function automatic longint fx_round(longint p);
    return (p + 64'sd32768) >>> 16;
  endfunction

  function automatic longint fx_clip(longint v, ref bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic void diff_mag(longint p1, longint p2, output logic [63:0] mag,
                                   output bit neg);
    if (p1 >= p2) begin
      mag = 64'(p1) - 64'(p2);
      neg = 1'b0;
    end else begin
      mag = 64'(p2) - 64'(p1);
      neg = 1'b1;
    end
  endfunction

  // -(num/det), truncated toward zero, clipped
  function automatic longint solve_quot(logic [63:0] nm, bit nneg, logic [63:0] dm, bit dneg,
                                        ref bit sat);
    bit          neg;
    logic [63:0] cap, q, r, res;
    neg = !(nneg ^ dneg);
    cap = (64'd1 << 31) - (neg ? 64'd0 : 64'd1);
    if (nm == 0 || dm == 0) return 0;
    q = nm / dm;
    r = nm % dm;
    if (q > cap) begin
      sat = 1'b1;
      res = cap;
    end else begin
      res = q;
      for (int i = 0; i < 16; i++) begin
        r = r << 1;
        res = res * 2;
        if (r >= dm) begin
          r = r - dm;
          res = res + 1;
        end
        if (res > cap) begin
          sat = 1'b1;
          res = cap;
          break;
        end
      end
    end
    return neg ? -longint'(res) : longint'(res);
  endfunction

  function automatic point_motion_t motion_of(logic [IN_BITS-1:0] d, logic [TOL_BITS-1:0] tol);
    longint        v[NV];
    longint        det, tr, ux, uy, sxx, sxy, syy, r0, r1, ax, ay;
    logic [63:0]   trm, detm, m, tw, k;
    logic [127:0]  lhs, rhs;
    bit            dneg, neg, sat;
    point_motion_t res;
    res = '0;
    sat = 1'b0;
    for (int i = 0; i < NV; i++) v[i] = longint'($signed(d[i*SLOT_BITS +: SLOT_BITS]));
    det = v[V_A] * v[V_C] - v[V_B] * v[V_B];
    tr = v[V_A] + v[V_C];
    if (det == 0) return res;
    dneg = det < 0;
    trm = tr < 0 ? 64'(-tr) : 64'(tr);
    detm = dneg ? 64'(-det) : 64'(det);
    tw = 64'(tol);
    k = dneg ? 64'(TOL_ONE) - tw : 64'(TOL_ONE) + tw;
    lhs = 128'(trm * (tw << TOL_BITS)) * 128'(trm);
    rhs = 128'(k * k) * 128'(detm);
    if (lhs >= rhs) return res;
    diff_mag(v[V_C] * v[V_GX], v[V_B] * v[V_GY], m, neg);
    ux = solve_quot(m, neg, detm, dneg, sat);
    diff_mag(v[V_A] * v[V_GY], v[V_B] * v[V_GX], m, neg);
    uy = solve_quot(m, neg, detm, dneg, sat);
    sxx = fx_clip(fx_round(ux * ux), sat);
    sxy = fx_clip(fx_round(ux * uy), sat);
    syy = fx_clip(fx_round(uy * uy), sat);
    r0 = v[V_XTT] + 2 * (fx_round(v[V_XXT] * ux) + fx_round(v[V_XYT] * uy))
       + fx_round(v[V_XXX] * sxx) + 2 * fx_round(v[V_XXY] * sxy) + fx_round(v[V_XYY] * syy);
    r1 = v[V_YTT] + 2 * (fx_round(v[V_XYT] * ux) + fx_round(v[V_YYT] * uy))
       + fx_round(v[V_XXY] * sxx) + 2 * fx_round(v[V_XYY] * sxy) + fx_round(v[V_YYY] * syy);
    r0 = fx_clip(r0, sat);
    r1 = fx_clip(r1, sat);
    diff_mag(v[V_C] * r0, v[V_B] * r1, m, neg);
    ax = solve_quot(m, neg, detm, dneg, sat);
    diff_mag(v[V_A] * r1, v[V_B] * r0, m, neg);
    ay = solve_quot(m, neg, detm, dneg, sat);
    res.point_valid = 1'b1;
    res.saturated = sat;
    res.vel_x = ux[31:0];
    res.vel_y = uy[31:0];
    res.acc_x = ax[31:0];
    res.acc_y = ay[31:0];
    return res;
  endfunction

  function automatic logic [31:0] scaled_value(int bits);
    return 32'($signed($urandom) >>> (32 - bits));
  endfunction

  function automatic logic [IN_BITS-1:0] point_from(logic [31:0] a, logic [31:0] b,
                                                     logic [31:0] c, logic [31:0] rest);
    logic [IN_BITS-1:0] d;
    for (int i = 0; i < NV; i++) d[i*SLOT_BITS +: SLOT_BITS] = rest;
    d[V_A*SLOT_BITS +: 32] = a;
    d[V_B*SLOT_BITS +: 32] = b;
    d[V_C*SLOT_BITS +: 32] = c;
    return d;
  endfunction

  function automatic logic [IN_BITS-1:0] random_point();
    logic [IN_BITS-1:0] d;
    int                 sel, hb;
    sel = $urandom_range(0, 9);
    for (int i = 0; i < NV; i++) d[i*SLOT_BITS +: SLOT_BITS] = $urandom;
    if (sel < 2) return d;
    for (int i = V_GX; i < NV; i++)
      d[i*SLOT_BITS +: SLOT_BITS] = scaled_value($urandom_range(4, (sel == 2) ? 32 : 22));
    hb = $urandom_range(14, 24);
    d[V_A*SLOT_BITS +: 32] = scaled_value(hb);
    d[V_C*SLOT_BITS +: 32] = scaled_value(hb);
    d[V_B*SLOT_BITS +: 32] = scaled_value($urandom_range(2, hb));
    if (sel == 3) d[V_C*SLOT_BITS +: 32] = scaled_value($urandom_range(2, 10));
    return d;
  endfunction

  function automatic void queue_point(logic [IN_BITS-1:0] d);
    pending_points = {pending_points, d};
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  int  send_gap = 0;
  bit  send_calm = 1'b0;
  bit  send_busy;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      send_busy = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_motion = {expected_motion, motion_of(s_axis_tdata, tolerance)};
        send_busy = 1'b0;
      end
      if (!send_busy) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_points.size() > 0) begin
          s_axis_tdata <= pending_points.pop_front();
          s_axis_tvalid <= 1'b1;
          if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
          send_gap = send_calm ? 0 : pick_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  int  stall = 0;
  bit  recv_calm = 1'b0;
  point_motion_t want, got;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL critical_point_velocity_acceleration_top");
      $finish;
    end
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.point_valid = m_axis_tuser[USR_VALID];
        got.saturated = m_axis_tuser[USR_SAT];
        got.vel_x = m_axis_tdata[O_VX*SLOT_BITS +: 32];
        got.vel_y = m_axis_tdata[O_VY*SLOT_BITS +: 32];
        got.acc_x = m_axis_tdata[O_AX*SLOT_BITS +: 32];
        got.acc_y = m_axis_tdata[O_AY*SLOT_BITS +: 32];
        if (expected_motion.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %h", $time, got);
        end else begin
          want = expected_motion.pop_front();
          if (got.point_valid !== want.point_valid)
            $display("%0t: point_valid exp %0d got %0d", $time, want.point_valid, got.point_valid);
          if (got.saturated !== want.saturated)
            $display("%0t: saturated exp %0d got %0d", $time, want.saturated, got.saturated);
          if (got.vel_x !== want.vel_x)
            $display("%0t: vel_x exp %h got %h", $time, want.vel_x, got.vel_x);
          if (got.vel_y !== want.vel_y)
            $display("%0t: vel_y exp %h got %h", $time, want.vel_y, got.vel_y);
          if (got.acc_x !== want.acc_x)
            $display("%0t: acc_x exp %h got %h", $time, want.acc_x, got.acc_x);
          if (got.acc_y !== want.acc_y)
            $display("%0t: acc_y exp %h got %h", $time, want.acc_y, got.acc_y);
          if (got !== want) errors++;
        end
      end
      if (stall > 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 49) == 0) recv_calm = !recv_calm;
        if (!recv_calm && $urandom_range(0, 2) == 0) stall = pick_gap();
      end
    end
  end

  // sampled away from the rising edge so the driver's updates have settled
  task automatic wait_idle();
    while (pending_points.size() > 0 || s_axis_tvalid || expected_motion.size() > 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_tolerance(logic [TOL_BITS-1:0] value);
    cfg_wen <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    tolerance = value;
  endtask

  logic [TOL_BITS-1:0] phase_tol[5];

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    // directed points
    queue_point('0);
    queue_point('1);
    queue_point(point_from(32'h0001_0000, 0, 32'h0001_0000, 32'h0000_8000));
    queue_point(point_from(32'h0001_0000, 0, 32'hffff_0000, 32'hfffe_8001));
    queue_point(point_from(32'h7fff_ffff, 0, 32'h7fff_ffff, 32'h7fff_ffff));
    queue_point(point_from(32'h8000_0000, 0, 32'h8000_0000, 32'h8000_0000));
    queue_point(point_from(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff));
    queue_point(point_from(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    // conditioning right at and just past the reset cutoff
    queue_point(point_from(32'h0001_0000, 0, 32'd66, 32'h0000_0100));
    queue_point(point_from(32'h0001_0000, 0, 32'd67, 32'h0000_0100));
    queue_point(point_from(32'h0001_0000, 0, 32'hffff_ffbe, 32'h0000_0100));
    queue_point(point_from(32'h0001_0000, 0, 32'hffff_ffbd, 32'h0000_0100));
    // tiny determinant drives the velocity into saturation
    queue_point(point_from(32'h0000_0100, 32'h0000_0001, 32'h0000_0100, 32'h7fff_0000));
    queue_point(point_from(32'h0002_0000, 32'h0001_0000, 32'h0002_0000, 32'h0040_0000));
    queue_point(point_from(32'h0002_0000, 32'h0002_0000, 32'h0002_0000, 32'h0001_0000));
    queue_point(point_from(32'h0000_0001, 0, 32'h0000_0001, 32'h0000_0001));
    queue_point(point_from(32'hffff_ffff, 0, 32'hffff_ffff, 32'h8000_0000));
    queue_point(point_from(32'h0001_0000, 32'h0000_8000, 32'h0001_0000, 32'h5555_5555));
    queue_point(point_from(32'h0001_0000, 32'h0000_8000, 32'h0001_0000, 32'haaaa_aaaa));
    phase_tol[0] = 16'd0;
    phase_tol[1] = 16'hffff;
    phase_tol[2] = 16'($urandom);
    phase_tol[3] = 16'($urandom_range(1, 4000));
    phase_tol[4] = TOL_RESET;
    for (int p = 0; p < 6; p++) begin
      for (int i = 0; i < 140; i++) queue_point(random_point());
      wait_idle();
      if (p < 5) write_tolerance(phase_tol[p]);
    end
    if (errors == 0) begin
      $display("PASS critical_point_velocity_acceleration_top");
    end else begin
      $display("FAIL critical_point_velocity_acceleration_top");
    end
    $finish;
  end

endmodule
